[rtl/core/bafs_pkg.sv]
// ----------------------------------------------------------------------------
// Bounded address FIFO with search: shared package
// Sizes, operation and status codes, control structs and the byte swap.
// ----------------------------------------------------------------------------
package bafs_pkg;

   localparam int DEPTH       = 64;
   localparam int ENTRY_W     = 32;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int LIMIT_W     = 7;
   localparam int OCC_W       = 7;
   localparam int CMP_W       = CNT_W + LIMIT_W;
   localparam int LIMIT_RESET = 50;

   typedef enum logic [1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_SEARCH = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE   = 3'b001,
      FSM_EXEC   = 3'b010,
      FSM_REDUCE = 3'b100
   } fsm_type;

   // Per-cell control: shift toward the head, load the push word, compare.
   typedef struct packed {
      logic shift;
      logic load;
      logic compare;
   } cell_ctl_type;

   // Row-level control from the sequencer.
   typedef struct packed {
      logic pop;
      logic push;
      logic search;
   } chain_ctl_type;

   function automatic logic [ENTRY_W-1:0] swap_bytes(input logic [ENTRY_W-1:0] v);
      swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

[rtl/core/bounded_address_fifo_with_search_top.sv]
// ----------------------------------------------------------------------------
// Bounded address FIFO with search: top level
// Streaming front end, sequencer and result register around the cell row.
// ----------------------------------------------------------------------------
// An item arrives on the req_ channel: req_tuser carries the operation (push,
// pop or search) and req_tdata the address. Every item produces exactly one
// item on the rsp_ channel: rsp_tuser carries the status and rsp_tdata the
// popped word (zero unless a pop succeeded) and the occupancy after the item.
// The limit on held entries, written through csr_wr_en / csr_wr_data by the user
// only while idle (not enforced by the block), saturates at the row length.
//
// The block works on one item at a time. A push, a pop, a search on an empty
// store and an unused operation code get their result registered on leaving the
// execute state; a search of a non-empty store passes the reduce state as well,
// because every cell compares in parallel into a registered hit flag and the
// flags are then OR-reduced in the following cycle. The next item is accepted in
// the cycle after the result is registered.
// A finished result waits in the output register while the next item is
// accepted; the block only holds off when it must register a new result and
// the previous one has not yet been taken.
// Reset empties the store at once (only the occupancy count is cleared) and
// sets the limit to 50.
// ----------------------------------------------------------------------------
module bounded_address_fifo_with_search_top
   import bafs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Input items.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // [31:0] address
   input  logic [1:0]          req_tuser,   // [1:0] func
   // Result items.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,   // [31:0] popped_address, [38:32] occupancy
   output logic [1:0]          rsp_tuser,   // [1:0] status
   // Limit register.
   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data
);

   fsm_type             state_ff, state_in;
   func_type            func_ff;
   logic [ENTRY_W-1:0]  addr_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [LIMIT_W-1:0]  limit_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0]  rsp_popped_ff, rsp_popped_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   chain_ctl_type       chain_ctl;
   logic [ENTRY_W-1:0]  head_entry;
   logic                any_hit;
   logic [CNT_W-1:0]    eff_limit;
   logic                out_free;
   logic                rsp_load;
   logic                accept;

   // The limit saturates at the row length.
   assign eff_limit = (CMP_W'(limit_ff) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                        : CNT_W'(limit_ff);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == FSM_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      chain_ctl     = '0;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_popped_in = '0;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (func_ff == FUNC_SEARCH && count_ff != '0) begin
               // Every cell compares now; the hits are reduced next cycle.
               chain_ctl.search = 1'b1;
               state_in         = FSM_REDUCE;
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = FSM_IDLE;
               case (func_ff)
                  FUNC_PUSH: begin
                     if (count_ff >= eff_limit) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        chain_ctl.push = 1'b1;
                        count_in       = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        chain_ctl.pop = 1'b1;
                        rsp_popped_in = head_entry;
                        count_in      = count_ff - CNT_W'(1);
                     end
                  end
                  FUNC_SEARCH: begin
                     rsp_status_in = STATUS_EMPTY;
                  end
                  default: begin
                     rsp_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         FSM_REDUCE: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = any_hit ? STATUS_OK : STATUS_NOT_FOUND;
               state_in      = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign rsp_occ_in   = OCC_W'(count_in);
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_W'(LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func_type'(req_tuser);
         addr_ff <= req_tdata;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_popped_ff <= rsp_popped_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   // Pushed words are stored byte-swapped; searches compare the address as given.
   bafs_chain u_chain (
      .clock      (clock),
      .ctl        (chain_ctl),
      .count      (count_ff),
      .push_data  (swap_bytes(addr_ff)),
      .key        (addr_ff),
      .head_entry (head_entry),
      .any_hit    (any_hit)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_occ_ff, rsp_popped_ff};

endmodule

[rtl/core/bafs_cell.sv]
// ----------------------------------------------------------------------------
// Bounded address FIFO with search: storage cell
// Holds one entry, takes its neighbor's entry on a pop and flags a match.
// ----------------------------------------------------------------------------
module bafs_cell
   import bafs_pkg::*;
(
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  logic                held,
   input  logic [ENTRY_W-1:0]  next_entry,
   input  logic [ENTRY_W-1:0]  load_data,
   input  logic [ENTRY_W-1:0]  key,
   output logic [ENTRY_W-1:0]  entry,
   output logic                hit
);

   logic [ENTRY_W-1:0] entry_ff;
   logic [ENTRY_W-1:0] entry_in;
   logic               hit_ff;
   logic               hit_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = next_entry;
      end else if (ctl.load) begin
         entry_in = load_data;
      end
   end

   assign hit_in = ctl.compare ? (held && (entry_ff == key)) : hit_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

[rtl/core/bafs_chain.sv]
// ----------------------------------------------------------------------------
// Bounded address FIFO with search: row of cells
// Cell 0 holds the oldest entry; a push lands in the first free cell.
// ----------------------------------------------------------------------------
module bafs_chain
   import bafs_pkg::*;
(
   input  logic                clock,
   input  chain_ctl_type       ctl,
   input  logic [CNT_W-1:0]    count,
   input  logic [ENTRY_W-1:0]  push_data,
   input  logic [ENTRY_W-1:0]  key,
   output logic [ENTRY_W-1:0]  head_entry,
   output logic                any_hit
);

   logic [ENTRY_W-1:0] entry_vec [DEPTH];
   logic [DEPTH-1:0]   hit_vec;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      cell_ctl_type       cell_ctl;
      logic [ENTRY_W-1:0] next_entry;
      logic               held;

      assign cell_ctl.shift   = ctl.pop;
      assign cell_ctl.load    = ctl.push && (count == CNT_W'(k));
      assign cell_ctl.compare = ctl.search;
      assign held             = CNT_W'(k) < count;

      if (k == DEPTH - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_mid
         assign next_entry = entry_vec[k+1];
      end

      bafs_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .held       (held),
         .next_entry (next_entry),
         .load_data  (push_data),
         .key        (key),
         .entry      (entry_vec[k]),
         .hit        (hit_vec[k])
      );
   end

   assign head_entry = entry_vec[0];
   assign any_hit    = |hit_vec;

endmodule

[sim/bounded_address_fifo_with_search_top_tb.sv]
// ----------------------------------------------------------------------------
// Bounded address FIFO with search: testbench
// Streams push, pop and search items into the block with random gaps on both
// sides, mirrors the store in a scoreboard and checks every result item.
// ----------------------------------------------------------------------------
module bounded_address_fifo_with_search_top_tb;
   import bafs_pkg::*;

   // Operation code 3 has no meaning; the block must answer it with a plain
   // OK and leave the store alone.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 140;
   localparam int PHASE_COUNT  = 10;

   // One expected result item.
   typedef struct {
      status_type           status;
      logic [ENTRY_W-1:0]   popped;
      logic [OCC_W-1:0]     occupancy;
   } fifo_result_type;

   // The scoreboard keeps its own copy of the store as a queue of stored
   // (byte-swapped) words, oldest first, together with the current limit.
   class addr_fifo_mirror_type;
      logic [ENTRY_W-1:0] held[$];
      int unsigned        limit = LIMIT_RESET;
      fifo_result_type    awaited[$];
      int                 error_count = 0;

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit = value;
      endfunction

      // Applies one accepted item to the mirrored store and queues the
      // result that the block has to return for it.
      function void note_request(logic [1:0] func, logic [ENTRY_W-1:0] addr);
         fifo_result_type    r;
         int unsigned        room;
         logic [ENTRY_W-1:0] net_order;
         r.status    = STATUS_OK;
         r.popped    = '0;
         room        = (limit > DEPTH) ? DEPTH : limit;
         net_order   = {<<8{addr}};
         case (func)
            FUNC_PUSH: begin
               if (held.size() >= room) r.status = STATUS_FULL;
               else held.push_back(net_order);
            end
            FUNC_POP: begin
               if (held.size() == 0) r.status = STATUS_EMPTY;
               else r.popped = held.pop_front();
            end
            FUNC_SEARCH: begin
               // The search key is compared as given, with no byte swap.
               if (held.size() == 0) begin
                  r.status = STATUS_EMPTY;
               end else begin
                  r.status = STATUS_NOT_FOUND;
                  foreach (held[i]) if (held[i] == addr) r.status = STATUS_OK;
               end
            end
            default: ;
         endcase
         r.occupancy = OCC_W'(held.size());
         awaited.push_back(r);
      endfunction

      function void check_response(logic [1:0] status, logic [ENTRY_W-1:0] popped,
                                   logic [OCC_W-1:0] occupancy);
         fifo_result_type e;
         if (awaited.size() == 0) begin
            if (error_count < 10)
               $display("unexpected result item: status %0d popped %h occupancy %0d",
                        status, popped, occupancy);
            error_count++;
            return;
         end
         e = awaited.pop_front();
         if (status !== e.status || popped !== e.popped || occupancy !== e.occupancy) begin
            if (error_count < 10) begin
               $write("result mismatch: expected status %0d popped %h occupancy %0d,",
                      e.status, e.popped, e.occupancy);
               $display(" got status %0d popped %h occupancy %0d",
                        status, popped, occupancy);
            end
            error_count++;
         end
      endfunction
   endclass

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata   = '0;   // [31:0] address
   logic [1:0]          req_tuser   = '0;   // [1:0] func
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [39:0]         rsp_tdata;          // [31:0] popped_address, [38:32] occupancy
   logic [1:0]          rsp_tuser;          // [1:0] status
   logic                csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data = '0;

   addr_fifo_mirror_type mirror = new();
   int                   cycle_count = 0;
   int                   send_burst  = 0;
   int                   take_burst  = 0;

   // A small set of addresses that recur, so that pushes collide and
   // searches for their swapped form hit.
   logic [ENTRY_W-1:0] addr_pool[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
                                        32'hA5A5_5A5A, 32'h0000_00FF, 32'hFF00_0000,
                                        32'h0102_0304, 32'h8000_0001};

   // Limits for the random phases: full row, one, zero, above the row length,
   // small ones and the reset value. Push-heavy phases fill the store so that
   // the limit is reached; the others drain it.
   int unsigned phase_limit[PHASE_COUNT] = '{64, 1, 0, 127, 3, 64, 100, 2, 50, 37};
   bit          phase_fill[PHASE_COUNT]  = '{1, 0, 0, 1, 0, 0, 1, 0, 1, 0};

   bounded_address_fifo_with_search_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bounded_address_fifo_with_search_top_tb: done, errors");
         $finish;
      end
   end

   // Gap before the next item on one side: drawn at random, with occasional
   // bursts of back-to-back items so that full-rate stretches occur too.
   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(10, 40);
      return $urandom_range(0, 10);
   endfunction

   // Offers one item and waits for the edge at which it is taken. Valid is
   // only lowered when a gap follows, so it is never dropped and raised again
   // in the same step.
   task automatic send_item(input logic [1:0] func, input logic [ENTRY_W-1:0] addr);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
      mirror.note_request(func, addr);
   endtask

   // Most searches look for a word that is held right now, so that hits land
   // at every position of the store; the rest look for pool words or noise.
   task automatic send_random_item(input bit fill_heavy);
      int                 pick;
      int                 way;
      logic [1:0]         func;
      logic [ENTRY_W-1:0] addr;
      pick = $urandom_range(0, 99);
      addr = $urandom;
      if (pick < 3) begin
         func = FUNC_UNUSED;
      end else if (pick < (fill_heavy ? 73 : 38)) begin
         func = FUNC_PUSH;
         if ($urandom_range(0, 1)) addr = addr_pool[$urandom_range(0, 7)];
      end else if (pick < (fill_heavy ? 83 : 73)) begin
         func = FUNC_POP;
      end else begin
         func = FUNC_SEARCH;
         way  = $urandom_range(0, 9);
         if (way < 6 && mirror.held.size() != 0)
            addr = mirror.held[$urandom_range(0, mirror.held.size() - 1)];
         else if (way < 8)
            addr = {<<8{addr_pool[$urandom_range(0, 7)]}};
      end
      send_item(func, addr);
   endtask

   // Waits until every result has come back and the block has settled, then
   // writes a new limit. Every item gives a result, so an empty expectation
   // queue means the block is idle.
   task automatic settle_and_set_limit(input logic [LIMIT_W-1:0] value);
      req_tvalid <= 1'b0;
      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mirror.set_limit(value);
   endtask

   // Result side: random stalls on tready, and every item taken is checked.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(take_burst);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         mirror.check_response(rsp_tuser, rsp_tdata[31:0], rsp_tdata[38:32]);
      end
   end

   initial begin
      logic [LIMIT_W-1:0] next_limit;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset limit: operations on an empty store,
      // the unused code, extreme addresses, a search hit on the swapped word
      // and a miss on the unswapped one, then draining past empty.
      send_item(FUNC_POP, 32'h0000_0000);
      send_item(FUNC_SEARCH, 32'h0000_0000);
      send_item(FUNC_UNUSED, 32'h0000_0000);
      send_item(FUNC_PUSH, 32'h0000_0000);
      send_item(FUNC_PUSH, 32'hFFFF_FFFF);
      send_item(FUNC_PUSH, 32'h1234_5678);
      send_item(FUNC_SEARCH, 32'h7856_3412);
      send_item(FUNC_SEARCH, 32'h1234_5678);
      send_item(FUNC_SEARCH, 32'hFFFF_FFFF);
      send_item(FUNC_SEARCH, 32'h0000_0000);
      send_item(FUNC_UNUSED, 32'hFFFF_FFFF);
      send_item(FUNC_POP, 32'hFFFF_FFFF);
      send_item(FUNC_POP, 32'h0000_0000);
      send_item(FUNC_POP, 32'h0000_0000);
      send_item(FUNC_POP, 32'h0000_0000);

      // Random phases, each under its own limit; the last limit is drawn.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         next_limit = (phase == PHASE_COUNT - 1) ? LIMIT_W'($urandom_range(4, 126))
                                                 : LIMIT_W'(phase_limit[phase]);
         settle_and_set_limit(next_limit);
         repeat (PHASE_ITEMS) send_random_item(phase_fill[phase]);
      end

      req_tvalid <= 1'b0;
      while (mirror.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.error_count == 0)
         $display("bounded_address_fifo_with_search_top_tb: done, clean");
      else
         $display("bounded_address_fifo_with_search_top_tb: done, errors");
      $finish;
   end

endmodule
